### rtl/core/aesp_pkg.sv
// Shared types and constants for the audio effect sample processor.
package aesp_pkg;

  typedef enum logic [1:0] {
    MODE_CLEAN = 2'd0,
    MODE_CLIP  = 2'd1,
    MODE_DELAY = 2'd2,
    MODE_CRUSH = 2'd3
  } effect_mode_t;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_CLIP  = 2'd1;
  localparam logic [1:0] REG_DEPTH = 2'd2;
  localparam logic [1:0] REG_SHIFT = 2'd3;

  localparam int ADDR_W = 4;

  localparam effect_mode_t MODE_RESET  = MODE_CLEAN;
  localparam logic [14:0]  CLIP_RESET  = 15'd6000;
  localparam logic [8:0]   DEPTH_RESET = 9'd200;
  localparam logic [3:0]   SHIFT_RESET = 4'd2;

  localparam logic [15:0] SIGN_FLIP = 16'h8000;

  // Settings the effect datapath needs.
  typedef struct packed {
    effect_mode_t mode;
    logic [14:0]  clip_threshold;
    logic [3:0]   crush_shift;
  } fx_cfg_t;

endpackage

### rtl/core/aesp_if.sv
// Valid/ready channels for converter words in and processed words out.
interface aesp_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] adc_word;

  modport source (output valid, output adc_word, input ready);
  modport sink   (input valid, input adc_word, output ready);
endinterface

interface aesp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] processed_sample;
  logic [7:0]         pwm_high;
  logic [7:0]         pwm_low;

  modport source (output valid, output processed_sample, output pwm_high,
                  output pwm_low, input ready);
  modport sink   (input valid, input processed_sample, input pwm_high,
                  input pwm_low, output ready);
endinterface

### rtl/core/aesp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module aesp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic                                         re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/core/aesp_effect.sv
// Effect datapath: sign flip, clip, echo mix, crusher and PWM byte split.
module aesp_effect import aesp_pkg::*; (
  input  fx_cfg_t            cfg,
  input  logic [15:0]        word,
  input  logic [7:0]         entry,
  output logic signed [15:0] result,
  output logic [7:0]         pwm_high,
  output logic [7:0]         pwm_low
);

  logic signed [15:0] sample;
  logic [15:0]        echo_sum;

  assign sample   = signed'(word ^ SIGN_FLIP);
  assign echo_sum = word + {entry, word[7:0]};

  always_comb begin
    case (cfg.mode)
      MODE_CLIP: begin
        result = (sample > signed'({1'b0, cfg.clip_threshold}))
               ? signed'({1'b0, cfg.clip_threshold}) : sample;
      end
      MODE_DELAY: result = signed'(echo_sum);
      MODE_CRUSH: result = sample >>> cfg.crush_shift;
      default:    result = sample;
    endcase
  end

  // Offset binary high byte: adding 0x8000 only flips the top bit.
  assign pwm_high = result[15:8] ^ 8'h80;
  assign pwm_low  = result[7:0];

endmodule

### rtl/core/audio_effect_sample_processor.sv
// Top level of the audio effect sample processor: config port, echo ring and pipeline.
//
//   channel   | dir | handshake              | payload
//   ----------+-----+------------------------+-----------------------------------
//   in_ch     | in  | valid/ready            | adc_word[15:0]
//   out_ch    | out | valid/ready            | processed_sample, pwm_high, pwm_low
//   config    | in  | APB psel/penable/pready| paddr[3:0], pwdata, prdata
//
// One word is accepted every cycle when the sink keeps up; each word passes
// through the input stage, then the output register, before it leaves.
// The input stage of the two-stage pipeline lines up with the registered read port of the echo RAM.
// After reset the echo RAM is swept to zero, one entry a cycle, across all
// RING_CAPACITY entries; in_ch.ready stays low during the sweep.
// A stall on out_ch holds the output register and then the input stage;
// outside the sweep, ready drops only when both are full.
module audio_effect_sample_processor import aesp_pkg::*; #(
  parameter int RING_CAPACITY = 256
) (
  input  logic              clk,
  input  logic              rst,
  aesp_in_if.sink           in_ch,
  aesp_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int PW = (RING_CAPACITY > 1) ? $clog2(RING_CAPACITY) : 1;
  // Compare width wide enough for both the depth register and the position.
  localparam int CW = (PW + 1 > 9) ? PW + 1 : 9;

  // Configuration registers.
  effect_mode_t effect_mode;
  logic [14:0]  clip_threshold;
  logic [8:0]   echo_len;
  logic [3:0]   crush_shift;

  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode    <= MODE_RESET;
      clip_threshold <= CLIP_RESET;
      echo_len       <= DEPTH_RESET;
      crush_shift    <= SHIFT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_MODE:  effect_mode    <= effect_mode_t'(pwdata[1:0]);
        REG_CLIP:  clip_threshold <= pwdata[14:0];
        REG_DEPTH: echo_len       <= pwdata[8:0];
        REG_SHIFT: crush_shift    <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_MODE:  prdata = {30'd0, effect_mode};
      REG_CLIP:  prdata = {17'd0, clip_threshold};
      REG_DEPTH: prdata = {23'd0, echo_len};
      REG_SHIFT: prdata = {28'd0, crush_shift};
      default:   prdata = '0;
    endcase
  end

  // Echo ring: position, clearing sweep and RAM.
  logic [PW-1:0] ring_position;
  logic [PW-1:0] ring_position_next;
  logic [PW:0]   pos_inc;
  logic          pos_wrap;
  logic          clearing;
  logic [PW-1:0] clr_addr;

  logic          accept;
  logic          is_delay;
  logic          ram_we;
  logic [PW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;

  assign pos_inc  = {1'b0, ring_position} + (PW+1)'(1);
  // Wrap at the configured depth or at the ring capacity, whichever comes first.
  assign pos_wrap = (CW'(pos_inc) >= CW'(echo_len))
                 || (pos_inc >= (PW+1)'(RING_CAPACITY));
  assign ring_position_next = pos_wrap ? '0 : pos_inc[PW-1:0];

  assign is_delay = (effect_mode == MODE_DELAY);

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + PW'(1);
      if (clr_addr == PW'(RING_CAPACITY - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_position <= '0;
    end else if (accept && is_delay) begin
      ring_position <= ring_position_next;
    end
  end

  // Write this word's low byte at the current position and read the entry at
  // the next one in the same cycle; the read data is held until the next accept in delay mode.
  assign ram_we    = clearing || (accept && is_delay);
  assign ram_waddr = clearing ? clr_addr : ring_position;
  assign ram_wdata = clearing ? 8'd0 : in_ch.adc_word[7:0];

  aesp_ram #(
    .WIDTH (8),
    .DEPTH (RING_CAPACITY)
  ) u_echo_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept && is_delay),
    .raddr (ring_position_next),
    .rdata (ram_rdata)
  );

  // Input stage.
  logic        s1_valid;
  logic [15:0] s1_word;
  logic        s1_fwd;
  logic        s1_move;

  // Output register.
  logic               s2_valid;
  logic               s2_load;
  logic signed [15:0] s2_sample;
  logic [7:0]         s2_pwm_high;
  logic [7:0]         s2_pwm_low;

  assign s2_load     = !s2_valid || out_ch.ready;
  assign s1_move     = s1_valid && s2_load;
  assign in_ch.ready = !clearing && (!s1_valid || s2_load);
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // When the ring is one entry long the read hits the entry being written:
  // take the fresh low byte instead of the old RAM contents.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word <= in_ch.adc_word;
      s1_fwd  <= (ring_position_next == ring_position);
    end
  end

  fx_cfg_t            fx_cfg;
  logic [7:0]         fx_entry;
  logic signed [15:0] fx_result;
  logic [7:0]         fx_pwm_high;
  logic [7:0]         fx_pwm_low;

  assign fx_cfg   = '{mode: effect_mode, clip_threshold: clip_threshold,
                      crush_shift: crush_shift};
  assign fx_entry = s1_fwd ? s1_word[7:0] : ram_rdata;

  aesp_effect u_effect (
    .cfg      (fx_cfg),
    .word     (s1_word),
    .entry    (fx_entry),
    .result   (fx_result),
    .pwm_high (fx_pwm_high),
    .pwm_low  (fx_pwm_low)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      s2_sample   <= fx_result;
      s2_pwm_high <= fx_pwm_high;
      s2_pwm_low  <= fx_pwm_low;
    end
  end

  assign out_ch.valid            = s2_valid;
  assign out_ch.processed_sample = s2_sample;
  assign out_ch.pwm_high         = s2_pwm_high;
  assign out_ch.pwm_low          = s2_pwm_low;

endmodule

### rtl/core/aesp_checker.sv
// Port-level checks for the audio effect sample processor, bound to the top level.
module aesp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_sample,
  input logic [7:0]  out_pwm_high,
  input logic [7:0]  out_pwm_low
);

  // A stalled output word stays and holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_sample))
    else $error("output word changed while stalled");

  a_pwm_high: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_pwm_high == (out_sample[15:8] ^ 8'h80))
    else $error("pwm_high is not the offset-binary high byte");

  a_pwm_low: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_pwm_low == out_sample[7:0])
    else $error("pwm_low is not the low byte of the sample");

  // The echo ring sweep keeps input closed right after reset.
  a_clear_blocks: assert property (@(posedge clk)
    !rst && $past(rst) |-> !in_ready)
    else $error("input accepted during echo ring clear");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output word valid right after reset");

endmodule

bind audio_effect_sample_processor aesp_checker u_aesp_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_sample   (out_ch.processed_sample),
  .out_pwm_high (out_ch.pwm_high),
  .out_pwm_low  (out_ch.pwm_low)
);

### tb/tb.sv
// Self-checking testbench for the audio effect sample processor.
module tb;
  import aesp_pkg::*;

  localparam int ECHO_DEPTH    = 256;     // ring entries, same as the block's RING_CAPACITY
  localparam int CYCLE_LIMIT   = 200000;  // far above the slowest legal run
  localparam int SETTLE_CYCLES = 6;       // two-stage pipeline plus margin
  localparam int MAX_REPORTS   = 10;

  // One processed word as it leaves the output channel.
  typedef struct packed {
    logic signed [15:0] sample;
    logic [7:0]         pwm_hi;
    logic [7:0]         pwm_lo;
  } fx_word_t;

  logic        clk     = 1'b0;
  logic        rst     = 1'b1;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  aesp_in_if  in_ch ();
  aesp_out_if out_ch ();

  audio_effect_sample_processor #(.RING_CAPACITY(ECHO_DEPTH)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the block's settings and echo ring, kept in step with
  // every register write and every accepted word.
  effect_mode_t fx_mode  = MODE_RESET;
  logic [14:0]  fx_clip  = CLIP_RESET;
  logic [8:0]   fx_depth = DEPTH_RESET;
  logic [3:0]   fx_shift = SHIFT_RESET;
  logic [7:0]   echo_ring [ECHO_DEPTH];
  logic [7:0]   echo_pos = '0;

  // Processed words still owed by the block, oldest first.
  fx_word_t pending_words[$];

  int words_in      = 0;
  int words_out     = 0;
  int mismatches    = 0;
  int cfg_writes    = 0;
  int mode_words[4] = '{0, 0, 0, 0};
  int cycle_count   = 0;

  // Idle control for both channels; stall_request asks the receiver for a
  // long hold-off, which its own process counts down.
  bit src_gaps_on   = 1'b1;
  bit sink_gaps_on  = 1'b1;
  int stall_request = 0;
  int stall_left    = 0;
  int sink_gap_left = 0;

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.adc_word = '0;
    out_ch.ready   = 1'b0;
  end

  initial begin
    forever #5 clk = ~clk;
  end

  // Mostly back-to-back, sometimes a short pause, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // Random converter word, biased toward the rails and the sign boundary.
  function automatic logic [15:0] random_word();
    case ($urandom_range(0, 11))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Compute the processed word for one converter word and advance the
  // shadow ring exactly as the block does in delay mode.
  function automatic fx_word_t predict_effect(logic [15:0] adc);
    logic signed [15:0] sample;
    logic signed [15:0] clip_level;
    logic signed [15:0] result;
    logic [8:0]         next_pos;
    logic [15:0]        offset_bin;
    fx_word_t           w;
    sample     = adc ^ SIGN_FLIP;
    clip_level = $signed({1'b0, fx_clip});
    case (fx_mode)
      MODE_CLIP: begin
        // clip the positive side only
        result = (sample > clip_level) ? clip_level : sample;
      end
      MODE_DELAY: begin
        // store the low byte, advance, wrap at the depth or the ring size
        echo_ring[echo_pos] = adc[7:0];
        next_pos = {1'b0, echo_pos} + 9'd1;
        if (next_pos >= fx_depth || next_pos >= ECHO_DEPTH) next_pos = '0;
        echo_pos = next_pos[7:0];
        result   = {echo_ring[echo_pos], adc[7:0]} + adc;
      end
      MODE_CRUSH: begin
        result = sample >>> fx_shift;
      end
      default: begin
        result = sample;
      end
    endcase
    offset_bin = result + SIGN_FLIP;
    w.sample = result;
    w.pwm_hi = offset_bin[15:8];
    w.pwm_lo = result[7:0];
    return w;
  endfunction

  function automatic void note_mismatch(string field, logic [15:0] exp_v, logic [15:0] act_v);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("tb: mismatch on %s: expected %h, got %h (cycle %0d)",
               field, exp_v, act_v, cycle_count);
  endfunction

  // Record each accepted input word and check each accepted output word.
  // The push comes first so a word is never checked before it is expected.
  always @(posedge clk) begin : word_scoreboard
    fx_word_t exp_w;
    if (!rst && in_ch.valid && in_ch.ready) begin
      pending_words.push_back(predict_effect(in_ch.adc_word));
      mode_words[fx_mode]++;
      words_in++;
    end
    if (!rst && out_ch.valid && out_ch.ready) begin
      words_out++;
      if (pending_words.size() == 0) begin
        note_mismatch("unexpected output word", 16'h0000, out_ch.processed_sample);
      end else begin
        exp_w = pending_words.pop_front();
        if (out_ch.processed_sample !== exp_w.sample)
          note_mismatch("processed_sample", exp_w.sample, out_ch.processed_sample);
        if (out_ch.pwm_high !== exp_w.pwm_hi)
          note_mismatch("pwm_high", {8'h00, exp_w.pwm_hi}, {8'h00, out_ch.pwm_high});
        if (out_ch.pwm_low !== exp_w.pwm_lo)
          note_mismatch("pwm_low", {8'h00, exp_w.pwm_lo}, {8'h00, out_ch.pwm_low});
      end
    end
  end

  // Receiver: a requested hold-off wins, then any random gap, else accept.
  always @(negedge clk) begin
    if (stall_request > 0) begin
      stall_left    = stall_request;
      stall_request = 0;
    end
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if (sink_gap_left > 0) begin
      out_ch.ready <= 1'b0;
      sink_gap_left--;
    end else begin
      out_ch.ready <= 1'b1;
      if (sink_gaps_on) sink_gap_left = pick_gap();
    end
  end

  // Watchdog: end the run if it hangs anywhere.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: timeout after %0d cycles, %0d words outstanding",
             cycle_count, pending_words.size());
    $display("tb: failure");
    $finish;
  end

  // Offer one word, after an optional idle gap, and hold it until taken.
  // valid stays high across back-to-back words.
  task automatic send_word(input logic [15:0] adc);
    int gap;
    gap = src_gaps_on ? pick_gap() : 0;
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.adc_word <= adc;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid after the last word of a burst.
  task automatic idle_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // Wait until every owed word is back, then let the pipeline settle.
  task automatic wait_drained();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write: setup then access phase; only done with the block idle.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    idle_input();
    wait_drained();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_MODE:  fx_mode  = effect_mode_t'(value[1:0]);
      REG_CLIP:  fx_clip  = value[14:0];
      REG_DEPTH: fx_depth = value[8:0];
      REG_SHIFT: fx_shift = value[3:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Reset settings, clean mode: rails and the sign boundary.
  task automatic test_clean_extremes();
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h8000);
    send_word(16'h7FFF);
    send_word(16'h00FF);
    send_word(16'hFF00);
  endtask

  // Clip: exactly at the threshold, just above, both rails, threshold extremes.
  task automatic test_clip_distortion();
    write_reg(REG_MODE, 32'(MODE_CLIP));
    send_word(16'h9770);  // sample equals the reset threshold, left alone
    send_word(16'h9771);  // one above, clipped
    send_word(16'hFFFF);
    send_word(16'h0000);  // most negative, never clipped
    write_reg(REG_CLIP, 32'd0);
    send_word(16'h8000);
    send_word(16'h8001);
    send_word(16'h7FFF);
    write_reg(REG_CLIP, 32'd32767);
    send_word(16'hFFFF);
  endtask

  // Crusher: reset shift, full shift on both rails, no shift.
  task automatic test_bit_crusher();
    write_reg(REG_MODE, 32'(MODE_CRUSH));
    send_word(16'h7FFD);  // small negative rounds toward minus infinity
    write_reg(REG_SHIFT, 32'd15);
    send_word(16'h0000);
    send_word(16'hFFFF);
    send_word(16'h7FFF);
    write_reg(REG_SHIFT, 32'd0);
    send_word(16'h1234);
  endtask

  // Delay: reset depth, then a one-entry ring and a zero depth, where the
  // position always falls back to the first entry.
  task automatic test_delay_short();
    write_reg(REG_MODE, 32'(MODE_DELAY));
    send_word(16'h12AB);
    send_word(16'h34CD);
    write_reg(REG_DEPTH, 32'd1);
    send_word(16'h0001);
    send_word(16'hFFFE);
    write_reg(REG_DEPTH, 32'd0);
    send_word(16'h80FF);
    send_word(16'h7F00);
  endtask

  // Depth beyond the ring size: run past one full turn so the ring
  // wraps at its capacity and old bytes come back as echo.
  task automatic test_ring_wrap();
    write_reg(REG_DEPTH, 32'd511);
    write_reg(REG_MODE, 32'(MODE_DELAY));
    repeat (262) send_word(random_word());
    write_reg(REG_DEPTH, 32'd256);
    repeat (10) send_word(random_word());
  endtask

  // Hold the receiver off for a long stretch while words keep coming, so
  // the pipeline fills and input ready drops; then pause until drained.
  task automatic test_backpressure();
    write_reg(REG_DEPTH, 32'd3);
    write_reg(REG_MODE, 32'(MODE_DELAY));
    src_gaps_on  = 1'b0;
    sink_gaps_on = 1'b0;
    @(negedge clk);
    stall_request = 80;
    repeat (20) send_word(random_word());
    idle_input();
    wait_drained();
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
    repeat (10) send_word(random_word());
  endtask

  // Random settings per phase, with extremes often, and random words;
  // delay is favored so the ring sees many depths.
  task automatic test_random_phases(input int word_budget);
    int sent;
    int burst;
    sent = 0;
    while (sent < word_budget) begin
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0: write_reg(REG_CLIP, 32'd0);
          1: write_reg(REG_CLIP, 32'd32767);
          default: write_reg(REG_CLIP, 32'($urandom_range(0, 32767)));
        endcase
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 6))
          0: write_reg(REG_DEPTH, 32'd0);
          1: write_reg(REG_DEPTH, 32'd1);
          2: write_reg(REG_DEPTH, 32'd2);
          3: write_reg(REG_DEPTH, 32'd256);
          4: write_reg(REG_DEPTH, 32'd511);
          default: write_reg(REG_DEPTH, 32'($urandom_range(1, 256)));
        endcase
      end
      if ($urandom_range(0, 1) == 0) begin
        case ($urandom_range(0, 3))
          0: write_reg(REG_SHIFT, 32'd0);
          1: write_reg(REG_SHIFT, 32'd15);
          default: write_reg(REG_SHIFT, 32'($urandom_range(0, 15)));
        endcase
      end
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_MODE, 32'(MODE_DELAY));
      else
        write_reg(REG_MODE, 32'($urandom_range(0, 3)));
      // some phases run with no idling at all
      src_gaps_on  = ($urandom_range(0, 3) != 0);
      sink_gaps_on = ($urandom_range(0, 3) != 0);
      burst = $urandom_range(8, 40);
      repeat (burst) send_word(random_word());
      sent += burst;
    end
    src_gaps_on  = 1'b1;
    sink_gaps_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < ECHO_DEPTH; i++) echo_ring[i] = '0;
    // hold reset, then release at a falling edge; the block then sweeps
    // its echo RAM with input ready low, which send_word simply waits out
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_clean_extremes();
    test_clip_distortion();
    test_bit_crusher();
    test_delay_short();
    test_ring_wrap();
    test_backpressure();
    test_random_phases(70);

    idle_input();
    wait_drained();

    $display("tb: %0d words in, %0d out (clean %0d, clip %0d, delay %0d, crush %0d)",
             words_in, words_out, mode_words[0], mode_words[1], mode_words[2],
             mode_words[3]);
    $display("tb: %0d register writes incl. zero and beyond-ring depths, %0d mismatches",
             cfg_writes, mismatches);
    if (mismatches == 0 && pending_words.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
